// ===== rtl/sewr_pkg.sv =====
`timescale 1ns / 1ps

package sewr_pkg;

  // Default stack depth.
  localparam int DEPTH_DEFAULT = 64;

  // Field widths.
  localparam int MODE_W = 4;
  localparam int WORD_W = 32;
  localparam int RCNT_W = 7;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 7;

  typedef logic [MODE_W-1:0]        mode_t;
  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [RCNT_W-1:0]        rcount_t;
  typedef logic [STAT_W-1:0]        status_t;
  typedef logic [OCC_W-1:0]         occ_t;

  // Operation codes.
  localparam mode_t MODE_PUSH       = 4'd0;
  localparam mode_t MODE_POP        = 4'd1;
  localparam mode_t MODE_PEEK       = 4'd2;
  localparam mode_t MODE_DUP        = 4'd3;
  localparam mode_t MODE_SWAP       = 4'd4;
  localparam mode_t MODE_DUMP_CLEAR = 4'd5;
  localparam mode_t MODE_REV_ALL    = 4'd6;
  localparam mode_t MODE_REV_N      = 4'd7;
  localparam mode_t MODE_DUMP       = 4'd8;

  // Status codes.
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_OVERFLOW = 2'd1;
  localparam status_t ST_EMPTY    = 2'd2;
  localparam status_t ST_ONE      = 2'd3;

  // One result as it leaves the sequencer.
  typedef struct packed {
    status_t status;
    word_t   word;
    occ_t    occupancy;
    logic    last;
  } res_t;

endpackage

// ===== rtl/sewr_if.sv =====
`timescale 1ns / 1ps

// Command channel: one transaction carries one stack operation.
interface sewr_cmd_if import sewr_pkg::*; ();
  logic    valid;
  logic    ready;
  mode_t   mode;
  word_t   push_value;
  rcount_t reverse_count;

  modport source (output valid, output mode, output push_value, output reverse_count,
                  input ready);
  modport sink (input valid, input mode, input push_value, input reverse_count,
                output ready);
endinterface

// Response channel: one transaction carries one result.
interface sewr_rsp_if import sewr_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  word_t   word;
  occ_t    occupancy;
  logic    last;

  modport source (output valid, output status, output word, output occupancy,
                  output last, input ready);
  modport sink (input valid, input status, input word, input occupancy, input last,
                output ready);
endinterface

// ===== rtl/sewr_ram.sv =====
`timescale 1ns / 1ps

module sewr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and a read port whose data holds until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sewr_ctrl.sv =====
`timescale 1ns / 1ps

module sewr_ctrl import sewr_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  sewr_cmd_if.sink     cmd,
  output logic         res_valid,
  output res_t         res,
  input  logic         res_ready
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EMIT   = 3'd1;
  localparam logic [2:0] S_PEEK   = 3'd2;
  localparam logic [2:0] S_DUP    = 3'd3;
  localparam logic [2:0] S_RV_HI  = 3'd4;
  localparam logic [2:0] S_RV_WLO = 3'd5;
  localparam logic [2:0] S_RV_WHI = 3'd6;
  localparam logic [2:0] S_DUMP   = 3'd7;

  logic [2:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] lo, lo_next;
  logic [AW-1:0] hi, hi_next;
  word_t         hold, hold_next;
  logic          more, more_next;
  logic          dump_clear, dump_clear_next;
  status_t       res_status, res_status_next;
  word_t         res_word, res_word_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  word_t         ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic          is_empty;
  logic          is_full;
  logic [AW-1:0] top_addr;
  logic [CW-1:0] rev_len;

  sewr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cmd.ready = (state == S_IDLE);

  // Occupancy decode and the length of a reversal of the oldest entries.
  assign is_empty = (count == '0);
  assign is_full  = (count == CW'(DEPTH));
  assign top_addr = AW'(count - CW'(1));
  assign rev_len  = (OCC_W'(cmd.reverse_count) >= OCC_W'(count)) ?
                    count : CW'(cmd.reverse_count);

  // Sequencer: issues memory reads and writes and builds the results.
  always_comb begin
    state_next      = state;
    count_next      = count;
    lo_next         = lo;
    hi_next         = hi;
    hold_next       = hold;
    more_next       = more;
    dump_clear_next = dump_clear;
    res_status_next = res_status;
    res_word_next   = res_word;
    ram_we          = 1'b0;
    ram_waddr       = lo;
    ram_wdata       = word_t'(ram_rdata);
    ram_re          = 1'b0;
    ram_raddr       = lo;
    res_valid       = 1'b0;
    res             = '0;

    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          res_status_next = ST_OK;
          res_word_next   = '0;
          state_next      = S_EMIT;
          case (cmd.mode) inside
            MODE_PUSH: begin
              if (is_full) begin
                res_status_next = ST_OVERFLOW;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(count);
                ram_wdata  = cmd.push_value;
                count_next = count + CW'(1);
              end
            end
            MODE_POP: begin
              if (is_empty) begin
                res_status_next = ST_EMPTY;
              end else begin
                count_next = count - CW'(1);
              end
            end
            MODE_PEEK: begin
              if (is_empty) begin
                res_status_next = ST_EMPTY;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = top_addr;
                state_next = S_PEEK;
              end
            end
            MODE_DUP: begin
              if (is_empty) begin
                res_status_next = ST_EMPTY;
              end else if (is_full) begin
                res_status_next = ST_OVERFLOW;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = top_addr;
                state_next = S_DUP;
              end
            end
            MODE_SWAP: begin
              if (is_empty) begin
                res_status_next = ST_EMPTY;
              end else if (count == CW'(1)) begin
                res_status_next = ST_ONE;
              end else begin
                // A swap is a reversal of the two newest entries.
                lo_next    = AW'(count - CW'(2));
                hi_next    = top_addr;
                ram_re     = 1'b1;
                ram_raddr  = AW'(count - CW'(2));
                state_next = S_RV_HI;
              end
            end
            MODE_DUMP_CLEAR, MODE_DUMP: begin
              if (is_empty) begin
                res_status_next = ST_EMPTY;
              end else begin
                ram_re          = 1'b1;
                ram_raddr       = top_addr;
                hi_next         = top_addr;
                dump_clear_next = (cmd.mode == MODE_DUMP_CLEAR);
                state_next      = S_DUMP;
              end
            end
            MODE_REV_ALL, MODE_REV_N: begin
              if (count >= CW'(2) &&
                  (cmd.mode == MODE_REV_ALL || cmd.reverse_count >= RCNT_W'(2))) begin
                lo_next    = '0;
                hi_next    = (cmd.mode == MODE_REV_ALL) ? top_addr : AW'(rev_len - CW'(1));
                ram_re     = 1'b1;
                ram_raddr  = '0;
                state_next = S_RV_HI;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_PEEK: begin
        res_word_next = word_t'(ram_rdata);
        state_next    = S_EMIT;
      end

      S_DUP: begin
        ram_we     = 1'b1;
        ram_waddr  = AW'(count);
        count_next = count + CW'(1);
        state_next = S_EMIT;
      end

      // The low entry of the pair is in the read register; fetch the high one.
      S_RV_HI: begin
        hold_next  = word_t'(ram_rdata);
        ram_re     = 1'b1;
        ram_raddr  = hi;
        state_next = S_RV_WLO;
      end

      // Store the high word low and, if another pair remains, start fetching the next low entry.
      S_RV_WLO: begin
        ram_we    = 1'b1;
        ram_waddr = lo;
        more_next = ((AW + 1)'(lo) + (AW + 1)'(2)) < (AW + 1)'(hi);
        if (((AW + 1)'(lo) + (AW + 1)'(2)) < (AW + 1)'(hi)) begin
          ram_re    = 1'b1;
          ram_raddr = lo + AW'(1);
        end
        lo_next    = lo + AW'(1);
        state_next = S_RV_WHI;
      end

      // Store the low word high; the next low word arrives in the same cycle.
      S_RV_WHI: begin
        ram_we    = 1'b1;
        ram_waddr = hi;
        ram_wdata = hold;
        if (more) begin
          hold_next  = word_t'(ram_rdata);
          ram_re     = 1'b1;
          ram_raddr  = hi - AW'(1);
          hi_next    = hi - AW'(1);
          state_next = S_RV_WLO;
        end else begin
          state_next = S_EMIT;
        end
      end

      S_EMIT: begin
        res_valid = 1'b1;
        res       = '{status: res_status, word: res_word, occupancy: OCC_W'(count),
                      last: 1'b1};
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      // Walk from the top down; the read data holds while the output stalls.
      S_DUMP: begin
        res_valid = 1'b1;
        res       = '{status: ST_OK, word: word_t'(ram_rdata),
                      occupancy: dump_clear ? '0 : OCC_W'(count),
                      last: (hi == '0)};
        if (res_ready) begin
          if (hi == '0) begin
            if (dump_clear) begin
              count_next = '0;
            end
            state_next = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = hi - AW'(1);
            hi_next   = hi - AW'(1);
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    lo         <= lo_next;
    hi         <= hi_next;
    hold       <= hold_next;
    more       <= more_next;
    dump_clear <= dump_clear_next;
    res_status <= res_status_next;
    res_word   <= res_word_next;
  end

`ifndef SYNTH
  // The fill level never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("stack count exceeds depth");

  // No cycle reads an entry that it writes.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re && ram_waddr == ram_raddr))
    else $error("read and write to the same entry in one cycle");

  // A reversal step always has its low pointer below its high pointer.
  a_rev_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_RV_WLO) |-> (lo < hi))
    else $error("reversal pointers crossed");

  // The final result of an operation returns the sequencer to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready && res.last) |=> (state == S_IDLE))
    else $error("sequencer busy after final result");
`endif

endmodule

// ===== rtl/stack_engine_with_reverse.sv =====
// Bounded LIFO stack of signed 32-bit words held in a single synchronous RAM, DEPTH entries
// deep. Each command transaction carries one operation and yields one response transaction,
// except a dump, which yields one per entry from the top down with last set on the final one.
// Each operation is paced by the single read and single write port of the RAM: push and pop
// update the stack and then emit; peek and duplicate first read the top entry; swap and
// reversals read each pair and write it back crosswise; a dump reads the next entry as each
// response is taken. A command is taken only while the sequencer is idle; a result that waits
// in the output register does not hold off the next command.
`timescale 1ns / 1ps

module stack_engine_with_reverse import sewr_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  sewr_cmd_if.sink  cmd,
  sewr_rsp_if.source rsp
);

  logic res_valid;
  logic res_ready;
  res_t res;
  logic out_valid;
  res_t out_data;

  sewr_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // The output register takes a new result when empty or being drained.
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res;
    end
  end

  // Response channel.
  assign rsp.valid     = out_valid;
  assign rsp.status    = out_data.status;
  assign rsp.word      = out_data.word;
  assign rsp.occupancy = out_data.occupancy;
  assign rsp.last      = out_data.last;

endmodule
